### sv/tga_rle_pixel_decoder_unit_defines.svh
// Assertion macros for the Targa decoder.
// Included by the top level; no other dependencies.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_DEFINES_SVH
// assert that an antecedent implies a consequent in the next cycle
`define TGA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
// assert an invariant
`define TGA_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`endif

### sv/tga_pkg.sv
// Shared types and constants for the Targa decoder.
// No dependencies.
package tga_pkg;
  localparam int unsigned HdrLen   = 18;
  localparam logic [7:0]  TypeRaw  = 8'd2;
  localparam logic [7:0]  TypeRle  = 8'd10;
  localparam logic [7:0]  CntMask  = 8'h7F;
  localparam logic [7:0]  RunFlag  = 8'h80;
  localparam int unsigned DimW     = 16;
  localparam int unsigned IdxW     = 32;

  localparam logic [2:0] PhHeader = 3'd0;
  localparam logic [2:0] PhIdSkip = 3'd1;
  localparam logic [2:0] PhRaw    = 3'd2;
  localparam logic [2:0] PhPktHdr = 3'd3;
  localparam logic [2:0] PhPktPix = 3'd4;
  localparam logic [2:0] PhIdle   = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic       start_div;   // launch division of pixel index by width
    logic [7:0] len;         // requested run length
    logic       reject;      // emit a rejection result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;              // division running or result waiting
  } dp_sts_t;
endpackage

### sv/tga_rle_pixel_decoder_unit.sv
// Targa truecolour decoder: one file byte per input transfer, one run per output transfer.
// Header, ID, packet and non-final pixel bytes are taken whenever the datapath is not busy; no run output.
// A pixel's last byte starts a restoring division of index by width; tvalid rises once
// the division ends, and the next byte is taken only after that result is accepted.
// A rejection is valid the cycle after the last header byte; input held while a result waits.
// Asynchronous active-low reset puts the parser at header byte 0, slot 0.
`include "tga_rle_pixel_decoder_unit_defines.svh"
module tga_rle_pixel_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,     // texture_slot
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] file_byte
  input  logic        s_axis_tuser,    // start_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,    // slot, red, green, blue, row, col, len, pad
  output logic        m_axis_tuser,    // result_kind
  output logic        m_axis_tlast     // image_complete
);
  import tga_pkg::*;

  logic [2:0]  slot_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [23:0] color;
  logic [15:0] width, height;
  logic [31:0] index, total;
  logic [7:0]  clip_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) slot_q <= 3'd0;
    else if (cfg_we_i) slot_q <= cfg_wdata_i;
  end

  tga_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .byte_i(s_axis_tdata), .sof_i(s_axis_tuser), .sts_i(sts), .clip_len_i(clip_len),
    .cmd_o(cmd), .color_o(color), .width_o(width), .height_o(height),
    .index_o(index), .total_o(total)
  );

  tga_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .slot_i(slot_q), .color_i(color),
    .width_i(width), .height_i(height), .index_i(index), .total_i(total),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(m_axis_tdata), .out_kind_o(m_axis_tuser), .out_last_o(m_axis_tlast),
    .clip_len_o(clip_len)
  );

  `TGA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, cmd.start_div, sts.busy, "divider not busy")
  `TGA_ASSERT_ALWAYS(a_no_double, clk_i, rst_ni, !(cmd.start_div && cmd.reject), "clash")
  `TGA_ASSERT_NEXT(a_rej_out, clk_i, rst_ni, cmd.reject, m_axis_tvalid, "reject lost")
endmodule

### sv/tga_datapath.sv
// Datapath: restoring divider for the pixel position, run clipping, output register.
// Depends on tga_pkg.
module tga_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tga_pkg::dp_cmd_t  cmd_i,
  output tga_pkg::dp_sts_t  sts_o,
  input  logic [2:0]        slot_i,
  input  logic [23:0]       color_i,
  input  logic [15:0]       width_i,
  input  logic [15:0]       height_i,
  input  logic [31:0]       index_i,
  input  logic [31:0]       total_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [71:0]       out_data_o,
  output logic              out_kind_o,
  output logic              out_last_o,
  output logic [7:0]        clip_len_o
);
  import tga_pkg::*;

  logic        run_q, run_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic        ov_q, ov_d;
  logic [71:0] od_q, od_d;
  logic        ok_q, ok_d;
  logic        ol_q, ol_d;
  logic [7:0]  len_q, len_d;
  logic        comp_q, comp_d;
  logic [2:0]  slot_q, slot_d;
  logic [23:0] col_q, col_d;
  logic [31:0] left;
  logic [7:0]  clip;
  logic [16:0] trial;
  logic [16:0] diff;
  logic [15:0] row, colm;

  assign left = total_i - index_i;
  assign clip = ({24'd0, cmd_i.len} > left) ? left[7:0] : cmd_i.len;
  assign clip_len_o = clip;
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, width_i};
  assign row  = height_i - 16'd1 - quo_q[15:0];
  assign colm = width_i - 16'd1 - rem_q;

  always_comb begin
    run_d = run_q; cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q;
    ov_d = ov_q; od_d = od_q; ok_d = ok_q; ol_d = ol_q; len_d = len_q; comp_d = comp_q;
    slot_d = slot_q; col_d = col_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (cmd_i.reject) begin
      ov_d = 1'b1;
      od_d = {69'd0, slot_i};
      ok_d = 1'b1;
      ol_d = 1'b0;
    end else if (cmd_i.start_div) begin
      run_d = 1'b1; cnt_d = 6'd0; quo_d = index_i; rem_d = 16'd0;
      len_d = clip; comp_d = ({24'd0, clip} == left);
      slot_d = slot_i; col_d = color_i;
    end else if (run_q) begin
      // one quotient bit per cycle
      if (trial >= {1'b0, width_i}) begin
        rem_d = diff[15:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) run_d = 1'b0;
    end else if (cnt_q == 6'd32 && !ov_d) begin
      cnt_d = 6'd0;
      ov_d = 1'b1;
      od_d = {5'd0, len_q, colm, row, col_q[7:0], col_q[15:8], col_q[23:16], slot_q};
      ok_d = 1'b0;
      ol_d = comp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; cnt_q <= 6'd0; ov_q <= 1'b0;
    end else begin
      run_q <= run_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; od_q <= od_d; ok_q <= ok_d; ol_q <= ol_d;
    len_q <= len_d; comp_q <= comp_d; slot_q <= slot_d; col_q <= col_d;
  end

  assign sts_o.busy  = run_q || (cnt_q == 6'd32) || ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_kind_o  = ok_q;
  assign out_last_o  = ol_q;
endmodule

### sv/tga_ctrl.sv
// Controller: header parser, packet sequencer and pixel byte gathering.
// Depends on tga_pkg.
module tga_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        byte_i,
  input  logic              sof_i,
  input  tga_pkg::dp_sts_t  sts_i,
  input  logic [7:0]        clip_len_i,
  output tga_pkg::dp_cmd_t  cmd_o,
  output logic [23:0]       color_o,
  output logic [15:0]       width_o,
  output logic [15:0]       height_o,
  output logic [31:0]       index_o,
  output logic [31:0]       total_o
);
  import tga_pkg::*;

  logic [2:0]  ph_q, ph_d;
  logic [4:0]  hc_q, hc_d;
  logic [7:0]  ids_q, ids_d, typ_q, typ_d, pl_q, pl_d;
  logic [15:0] w_q, w_d, h_q, h_d;
  logic [2:0]  bpp_q, bpp_d, bip_q, bip_d;
  logic        run_q, run_d;
  logic [23:0] col_q, col_d;
  logic [31:0] idx_q, idx_d, tot_q, tot_d;
  logic        acc, done_pix;
  logic [2:0]  ph, bip;
  logic [7:0]  pl;
  logic        rn;

  assign in_ready_o = !sts_i.busy;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    ph_d = ph_q; hc_d = hc_q; ids_d = ids_q; typ_d = typ_q; pl_d = pl_q;
    w_d = w_q; h_d = h_q; bpp_d = bpp_q; bip_d = bip_q; run_d = run_q;
    col_d = col_q; idx_d = idx_q; tot_d = tot_q;
    cmd_o = '0;
    done_pix = 1'b0;
    ph = ph_q; bip = bip_q; pl = pl_q; rn = run_q;
    if (acc) begin
      if (sof_i) begin
        ph = PhHeader; hc_d = 5'd0; idx_d = 32'd0; bip = 3'd0; pl = 8'd0; rn = 1'b0;
      end
      ph_d = ph; bip_d = bip; pl_d = pl; run_d = rn;
      if (sof_i) hc_d = 5'd0;
      unique case (ph) inside
        PhHeader: begin
          case (sof_i ? 5'd0 : hc_q)
            5'd0:  ids_d = byte_i;
            5'd2:  typ_d = byte_i;
            5'd12: w_d = {w_q[15:8], byte_i};
            5'd13: w_d = {byte_i, w_q[7:0]};
            5'd14: h_d = {h_q[15:8], byte_i};
            5'd15: h_d = {byte_i, h_q[7:0]};
            5'd16: bpp_d = byte_i[7:6] != 2'd0 ? 3'd0 : byte_i[5:3];
            default: ;
          endcase
          if ((sof_i ? 5'd0 : hc_q) == 5'(HdrLen - 1)) begin
            hc_d = 5'd0; idx_d = 32'd0;
            tot_d = w_q * h_q;
            if ((typ_q != TypeRaw && typ_q != TypeRle) ||
                (bpp_d != 3'd3 && bpp_d != 3'd4)) begin
              ph_d = PhIdle; cmd_o.reject = 1'b1;
            end else if (ids_q != 8'd0) ph_d = PhIdSkip;
            else begin
              bip_d = 3'd0;
              ph_d = (w_q == 16'd0 || h_q == 16'd0) ? PhIdle :
                     (typ_q == TypeRaw) ? PhRaw : PhPktHdr;
            end
          end else hc_d = (sof_i ? 5'd0 : hc_q) + 5'd1;
        end
        PhIdSkip: begin
          ids_d = ids_q - 8'd1;
          if (ids_q == 8'd1) begin
            bip_d = 3'd0;
            ph_d = (tot_q == 32'd0) ? PhIdle : (typ_q == TypeRaw) ? PhRaw : PhPktHdr;
          end
        end
        PhPktHdr: begin
          pl_d = (byte_i & CntMask) + 8'd1;
          run_d = (byte_i & RunFlag) != 8'd0;
          bip_d = 3'd0; ph_d = PhPktPix;
        end
        PhRaw, PhPktPix: begin
          if (bip < 3'd3) begin
            case (bip[1:0])
              2'd0: col_d[7:0] = byte_i;
              2'd1: col_d[15:8] = byte_i;
              default: col_d[23:16] = byte_i;
            endcase
          end
          bip_d = bip + 3'd1;
          if (bip + 3'd1 >= bpp_q) begin
            bip_d = 3'd0; done_pix = 1'b1;
          end
        end
        default: ;
      endcase
      if (done_pix) begin
        cmd_o.start_div = 1'b1;
        cmd_o.len = 8'd1;
        if (ph == PhPktPix) begin
          if (rn) begin
            cmd_o.len = pl; pl_d = 8'd0; ph_d = PhPktHdr;
          end else begin
            pl_d = pl - 8'd1;
            if (pl == 8'd1) ph_d = PhPktHdr;
          end
        end
        idx_d = idx_q + {24'd0, clip_len_i};
        if (idx_d >= tot_q) ph_d = PhIdle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhHeader; hc_q <= '0; ids_q <= '0; typ_q <= '0; pl_q <= '0;
      w_q <= '0; h_q <= '0; bpp_q <= '0; bip_q <= '0; run_q <= 1'b0;
      col_q <= '0; idx_q <= '0; tot_q <= '0;
    end else begin
      ph_q <= ph_d; hc_q <= hc_d; ids_q <= ids_d; typ_q <= typ_d; pl_q <= pl_d;
      w_q <= w_d; h_q <= h_d; bpp_q <= bpp_d; bip_q <= bip_d; run_q <= run_d;
      col_q <= col_d; idx_q <= idx_d; tot_q <= tot_d;
    end
  end

  assign color_o  = col_d;
  assign width_o  = w_q;
  assign height_o = h_q;
  assign index_o  = idx_q;
  assign total_o  = tot_q;
endmodule

### tb/sv/tga_rle_pixel_decoder_unit_tb.sv
// Testbench for tga_rle_pixel_decoder_unit: streams Targa files byte by byte and
// checks every output run against an in-bench decoder model.
// Depends on the RTL top level only.
module tga_rle_pixel_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] TypeRaw  = 8'd2;
  localparam logic [7:0] TypeRle  = 8'd10;
  localparam logic [7:0] CntMask  = 8'h7F;
  localparam logic [7:0] RunFlag  = 8'h80;
  localparam int         HdrBytes = 18;
  localparam int         StallLimit = 5000;

  typedef enum logic [2:0] {
    P_HEADER, P_IDSKIP, P_RAW, P_PKTHDR, P_PKTPIX, P_IDLE
  } parse_ph_e;

  typedef struct packed {
    logic        kind;
    logic [2:0]  slot;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  len;
    logic        complete;
  } run_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  tga_rle_pixel_decoder_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  logic [8:0] byte_q[$];     // {start_of_file, file_byte}
  run_t       runs_due[$];
  int         err_cnt = 0;
  int         cyc = 0;
  int         quiet = 0;

  // decoder model state
  logic [2:0]  m_slot = '0;
  parse_ph_e   m_ph = P_HEADER;
  logic [4:0]  m_hcnt = '0;
  logic [7:0]  m_idleft = '0, m_type = '0, m_pleft = '0;
  logic [15:0] m_w = '0, m_h = '0;
  logic [2:0]  m_bpp = '0, m_bip = '0;
  logic        m_isrun = 1'b0;
  logic [23:0] m_color = '0;
  logic [31:0] m_pidx = '0;

  function automatic void enter_pixels();
    if (32'(m_w) * 32'(m_h) == 0) m_ph = P_IDLE;
    else m_ph = (m_type == TypeRaw) ? P_RAW : P_PKTHDR;
    m_bip = '0;
  endfunction

  function automatic void push_run(logic [31:0] want);
    logic [31:0] total, len;
    run_t r;
    total = 32'(m_w) * 32'(m_h);
    len = want;
    if (len > total - m_pidx) len = total - m_pidx;
    r.kind = 1'b0;
    r.slot = m_slot;
    r.red = m_color[23:16];
    r.green = m_color[15:8];
    r.blue = m_color[7:0];
    r.row = 16'(32'(m_h) - 1 - m_pidx / 32'(m_w));
    r.col = 16'(32'(m_w) - 1 - m_pidx % 32'(m_w));
    r.len = len[7:0];
    m_pidx = m_pidx + len;
    r.complete = (m_pidx >= total);
    if (r.complete) m_ph = P_IDLE;
    runs_due.push_back(r);
  endfunction

  function automatic bit gather_byte(logic [7:0] b);
    if (m_bip < 3) m_color[8*m_bip +: 8] = b;
    m_bip = m_bip + 1;
    if (m_bip >= m_bpp) begin
      m_bip = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sof);
    run_t r;
    if (sof) begin
      m_ph = P_HEADER; m_hcnt = '0; m_pidx = '0; m_bip = '0;
      m_pleft = '0; m_isrun = 1'b0;
    end
    case (m_ph)
      P_HEADER: begin
        case (m_hcnt)
          0: m_idleft = b;
          2: m_type = b;
          12: m_w[7:0] = b;
          13: m_w[15:8] = b;
          14: m_h[7:0] = b;
          15: m_h[15:8] = b;
          16: m_bpp = (b / 8 > 7) ? 3'd0 : 3'(b / 8);
          default: ;
        endcase
        m_hcnt = m_hcnt + 1;
        if (m_hcnt == HdrBytes) begin
          m_hcnt = '0;
          m_pidx = '0;
          if ((m_type != TypeRaw && m_type != TypeRle) || (m_bpp != 3 && m_bpp != 4)) begin
            m_ph = P_IDLE;
            r = '0;
            r.kind = 1'b1;
            r.slot = m_slot;
            runs_due.push_back(r);
          end else if (m_idleft != 0) m_ph = P_IDSKIP;
          else enter_pixels();
        end
      end
      P_IDSKIP: begin
        m_idleft = m_idleft - 1;
        if (m_idleft == 0) enter_pixels();
      end
      P_RAW: if (gather_byte(b)) push_run(1);
      P_PKTHDR: begin
        m_pleft = (b & CntMask) + 8'd1;
        m_isrun = |(b & RunFlag);
        m_bip = '0;
        m_ph = P_PKTPIX;
      end
      P_PKTPIX: if (gather_byte(b)) begin
        if (m_isrun) begin
          m_ph = P_PKTHDR;
          push_run(32'(m_pleft));
          m_pleft = '0;
        end else begin
          m_pleft = m_pleft - 1;
          if (m_pleft == 0) m_ph = P_PKTHDR;
          push_run(1);
        end
      end
      default: ;
    endcase
  endfunction

  // a long calm window recurs periodically; random idling elsewhere
  function automatic bit idle_now();
    return (cyc % 20000) >= 3000 && $urandom_range(99) < 10;
  endfunction

  // driver: prediction happens on each accepted byte
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
    if (!s_axis_tvalid || s_axis_tready) begin
      if (byte_q.size() != 0 && rst_ni && !idle_now()) begin
        {s_axis_tuser, s_axis_tdata} <= byte_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // monitor; kind on tuser, image_complete on tlast
  always @(posedge clk_i) begin
    run_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (runs_due.size() == 0) begin
        $error("unexpected transfer, tdata %h", m_axis_tdata);
        err_cnt++;
      end else begin
        e = runs_due.pop_front();
        if (m_axis_tuser !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, m_axis_tuser); err_cnt++;
        end
        if (m_axis_tdata[2:0] !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, m_axis_tdata[2:0]); err_cnt++;
        end
        if (m_axis_tdata[10:3] !== e.red) begin
          $error("red exp %0d got %0d", e.red, m_axis_tdata[10:3]); err_cnt++;
        end
        if (m_axis_tdata[18:11] !== e.green) begin
          $error("green exp %0d got %0d", e.green, m_axis_tdata[18:11]); err_cnt++;
        end
        if (m_axis_tdata[26:19] !== e.blue) begin
          $error("blue exp %0d got %0d", e.blue, m_axis_tdata[26:19]); err_cnt++;
        end
        if (m_axis_tdata[42:27] !== e.row) begin
          $error("start_row exp %0d got %0d", e.row, m_axis_tdata[42:27]); err_cnt++;
        end
        if (m_axis_tdata[58:43] !== e.col) begin
          $error("start_col exp %0d got %0d", e.col, m_axis_tdata[58:43]); err_cnt++;
        end
        if (m_axis_tdata[66:59] !== e.len) begin
          $error("run_length exp %0d got %0d", e.len, m_axis_tdata[66:59]); err_cnt++;
        end
        if (m_axis_tlast !== e.complete) begin
          $error("image_complete exp %0d got %0d", e.complete, m_axis_tlast); err_cnt++;
        end
      end
    end
    m_axis_tready <= rst_ni && !idle_now();
  end

  // watchdog: no transfer for too long while work is pending
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (byte_q.size() == 0 && runs_due.size() == 0 && !s_axis_tvalid))
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > StallLimit) begin
      $display("tga_rle_pixel_decoder_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic void put_hdr(logic sof, logic [7:0] idl, logic [7:0] typ,
                                  logic [15:0] w, logic [15:0] h, logic [7:0] bits);
    logic [7:0] hdr[HdrBytes];
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = idl; hdr[2] = typ;
    hdr[12] = w[7:0]; hdr[13] = w[15:8]; hdr[14] = h[7:0]; hdr[15] = h[15:8];
    hdr[16] = bits;
    foreach (hdr[i]) byte_q.push_back({(i == 0) && sof, hdr[i]});
    for (int i = 0; i < idl; i++) byte_q.push_back({1'b0, 8'($urandom)});
  endfunction

  function automatic void put_pixel(int bpp);
    for (int i = 0; i < bpp; i++) byte_q.push_back({1'b0, 8'($urandom)});
  endfunction

  // one well-formed file with random content, small dimensions
  function automatic void put_file(logic [15:0] w, logic [15:0] h, logic rle, int bpp);
    int left;
    logic [7:0] ph;
    put_hdr(1'b1, 8'($urandom_range(0, 3)), rle ? TypeRle : TypeRaw, w, h, 8'(bpp * 8));
    left = int'(w) * int'(h);
    while (left > 0) begin
      if (!rle) begin
        put_pixel(bpp);
        left--;
      end else begin
        ph = 8'($urandom);
        if ($urandom_range(2) == 0) ph[6:0] = 7'($urandom_range(0, 5));
        byte_q.push_back({1'b0, ph});
        if (ph[7]) begin
          put_pixel(bpp);
          left -= int'(ph[6:0]) + 1;
        end else for (int i = 0; i <= ph[6:0] && left > 0; i++) begin
          put_pixel(bpp);
          left--;
        end
      end
    end
    // trailing junk is ignored once the image is complete
    for (int i = $urandom_range(0, 2); i > 0; i--) byte_q.push_back({1'b0, 8'($urandom)});
  endfunction

  task automatic drain(int hold);
    while (byte_q.size() != 0 || s_axis_tvalid || runs_due.size() != 0) @(posedge clk_i);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic set_slot(logic [2:0] v);
    drain(40);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    m_slot = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int sel;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a header without start marker straight after reset
    put_hdr(1'b0, 8'd0, TypeRaw, 16'd1, 16'd1, 8'd24);
    put_pixel(3);
    put_file(16'd2, 16'd2, 1'b1, 4);
    put_hdr(1'b1, 8'd0, 8'd3, 16'd2, 16'd2, 8'd24);       // unsupported type
    put_hdr(1'b1, 8'd0, TypeRle, 16'd2, 16'd2, 8'hFF);    // depth out of range
    put_hdr(1'b1, 8'd2, TypeRaw, 16'd0, 16'd5, 8'd32);    // empty image
    byte_q.push_back({1'b0, 8'hAA});
    // widest image: a full 128-pixel run then truncation
    put_hdr(1'b1, 8'd0, TypeRle, 16'hFFFF, 16'hFFFF, 8'd24);
    byte_q.push_back({1'b0, 8'hFF});
    put_pixel(3);
    // run clipped at the image end
    put_hdr(1'b1, 8'hFF, TypeRle, 16'd3, 16'd1, 8'd32);
    byte_q.push_back({1'b0, 8'hFF});
    put_pixel(4);
    // raw packet passing the image end
    put_hdr(1'b1, 8'd0, TypeRle, 16'd1, 16'd2, 8'd24);
    byte_q.push_back({1'b0, 8'h7F});
    put_pixel(3); put_pixel(3); put_pixel(3);

    for (int ph = 0; ph < 6; ph++) begin
      set_slot(ph == 0 ? 3'd7 : ph == 1 ? 3'd0 : 3'($urandom));
      while (byte_q.size() < 120) begin
        sel = $urandom_range(0, 19);
        if (sel < 15)
          put_file(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                   1'($urandom), $urandom_range(3, 4));
        else if (sel < 17)
          put_hdr(1'b1, 8'($urandom_range(0, 2)), 8'($urandom),
                  16'($urandom), 16'($urandom), 8'($urandom));
        else if (sel < 18)
          put_hdr(1'b1, 8'd0, TypeRaw, 16'($urandom_range(0, 1) * 3), 16'd0, 8'd24);
        else for (int i = $urandom_range(1, 30); i > 0; i--)
          byte_q.push_back({1'($urandom_range(0, 15) == 0), 8'($urandom)});
      end
    end
    drain(100);
    if (err_cnt == 0) $display("tga_rle_pixel_decoder_unit_tb: done, clean");
    else $display("tga_rle_pixel_decoder_unit_tb: done, errors");
    $finish;
  end
endmodule
